@@ src/x86d_pkg.sv @@
// Shared types, codes and decode helpers for the 16-bit x86 byte decoder.
// No dependencies; used by x86d_step and x86_16bit_instruction_byte_decoder.
`timescale 1ns / 1ps
`default_nettype none

package x86d_pkg;

    // Record status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_OP   = 2'd1,
        ST_TRUNC    = 2'd2,
        ST_BAD_GRP  = 2'd3
    } status_t;

    // Instruction classes; CLS_BAD marks an opcode outside the subset
    typedef enum logic [2:0] {
        CLS_MOV_RM  = 3'd0,
        CLS_MOV_IMM = 3'd1,
        CLS_ALU_RM  = 3'd2,
        CLS_ALU_IMM = 3'd3,
        CLS_ALU_ACC = 3'd4,
        CLS_JCC     = 3'd5,
        CLS_LOOP    = 3'd6,
        CLS_BAD     = 3'd7
    } cls_t;

    // ALU operation codes
    typedef enum logic [1:0] {
        ALU_ADD  = 2'd0,
        ALU_SUB  = 2'd1,
        ALU_CMP  = 2'd2,
        ALU_NONE = 2'd3
    } alu_t;

    // ALU selector values from opcode bits 5..3 or ModRM reg
    localparam logic [2:0] SEL_ADD = 3'd0;
    localparam logic [2:0] SEL_SUB = 3'd5;
    localparam logic [2:0] SEL_CMP = 3'd7;

    // ModRM direct address: mod 00 with rm 110
    localparam logic [2:0] RM_DIRECT = 3'b110;

    // Per-instruction collection state
    typedef struct packed {
        logic [7:0]  opcode;
        logic [7:0]  modrm;
        logic [15:0] disp;
        logic [15:0] imm;
        logic [2:0]  taken;
        logic        halted;
    } dec_state_t;

    // One decoded record
    typedef struct packed {
        status_t     status;
        logic [2:0]  instr_class;
        logic [3:0]  sub_op;
        logic        wide;
        logic        direction;
        logic        sign_ext;
        logic [1:0]  mode;
        logic [2:0]  reg_sel;
        logic [2:0]  rm_sel;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic [2:0]  instr_length;
    } dec_record_t;

    function automatic cls_t classify(input logic [7:0] op);
        cls_t c;
        c = CLS_BAD;
        if (op == 8'h04 || op == 8'h05 || op == 8'h2C || op == 8'h2D ||
            op == 8'h3C || op == 8'h3D)                         c = CLS_ALU_ACC;
        else if ((op & 8'b11111100) == 8'b10001000)             c = CLS_MOV_RM;
        else if ((op & 8'b11110000) == 8'b10110000)             c = CLS_MOV_IMM;
        else if ((op & 8'b11111100) == 8'b10000000)             c = CLS_ALU_IMM;
        else if ((op & 8'b11111100) == 8'b00000000 ||
                 (op & 8'b11111100) == 8'b00101000 ||
                 (op & 8'b11111100) == 8'b00111000)             c = CLS_ALU_RM;
        else if ((op & 8'b11110000) == 8'b01110000)             c = CLS_JCC;
        else if ((op & 8'b11111100) == 8'b11100000)             c = CLS_LOOP;
        return c;
    endfunction

    function automatic alu_t alu_code(input logic [2:0] sel);
        alu_t a;
        if (sel == SEL_ADD)      a = ALU_ADD;
        else if (sel == SEL_SUB) a = ALU_SUB;
        else if (sel == SEL_CMP) a = ALU_CMP;
        else                     a = ALU_NONE;
        return a;
    endfunction

    function automatic logic has_modrm(input cls_t c);
        return (c == CLS_MOV_RM) || (c == CLS_ALU_RM) || (c == CLS_ALU_IMM);
    endfunction

    // Displacement byte count from class and ModRM
    function automatic logic [1:0] disp_len(input cls_t c, input logic [7:0] modrm);
        logic [1:0] n;
        n = 2'd0;
        if (c == CLS_JCC || c == CLS_LOOP)                       n = 2'd1;
        else if (!has_modrm(c))                                  n = 2'd0;
        else if (modrm[7:6] == 2'd1)                             n = 2'd1;
        else if (modrm[7:6] == 2'd2)                             n = 2'd2;
        else if (modrm[7:6] == 2'd0 && modrm[2:0] == RM_DIRECT)  n = 2'd2;
        return n;
    endfunction

    // Immediate byte count from class and opcode
    function automatic logic [1:0] imm_len(input cls_t c, input logic [7:0] op);
        logic [1:0] n;
        n = 2'd0;
        if (c == CLS_MOV_IMM)      n = op[3] ? 2'd2 : 2'd1;
        else if (c == CLS_ALU_ACC) n = op[0] ? 2'd2 : 2'd1;
        else if (c == CLS_ALU_IMM) n = (op[0] && !op[1]) ? 2'd2 : 2'd1;
        return n;
    endfunction

    function automatic logic [15:0] sext8(input logic [15:0] v);
        return {{8{v[7]}}, v[7:0]};
    endfunction

endpackage

`default_nettype wire

@@ src/x86_16bit_instruction_byte_decoder.sv @@
// Top level of the 16-bit x86 instruction byte decoder: state and record
// registers around the decode step. Depends on x86d_pkg and x86d_step.
//
//  channel   dir  ports                                     one request is
//  s_        in   s_valid s_ready s_code_byte s_stream_end   one stream byte
//  m_        out  m_valid m_ready m_status ... m_instr_length one decoded record
//
// One byte per cycle while s_ready is high; a record appears the cycle
// after its last byte. The decode step is combinational between the state
// registers and the record register. s_ready falls only while a record
// waits and m_ready is low. Synchronous active-low reset clears the
// collection state and the record valid.
`timescale 1ns / 1ps
`default_nettype none

module x86_16bit_instruction_byte_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_code_byte,
    input  wire logic        s_stream_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [2:0]       m_instr_class,
    output logic [3:0]       m_sub_op,
    output logic             m_wide,
    output logic             m_direction,
    output logic             m_sign_ext,
    output logic [1:0]       m_mode,
    output logic [2:0]       m_reg_sel,
    output logic [2:0]       m_rm_sel,
    output logic [15:0]      m_displacement,
    output logic [15:0]      m_immediate,
    output logic [2:0]       m_instr_length
);

    x86d_pkg::dec_state_t  state_reg;
    x86d_pkg::dec_state_t  state_next;
    x86d_pkg::dec_record_t rec_reg;
    x86d_pkg::dec_record_t rec_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic                  emit;
    logic                  accept;

    x86d_step u_step (
        .code_byte  (s_code_byte),
        .stream_end (s_stream_end),
        .cur        (state_reg),
        .nxt        (state_next),
        .emit       (emit),
        .rec        (rec_next)
    );

    // Accept while the record register is empty or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (accept) m_valid_next = emit;
    end

    // Advance the collection state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Hold the record until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) rec_reg <= rec_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = rec_reg.status;
    assign m_instr_class  = rec_reg.instr_class;
    assign m_sub_op       = rec_reg.sub_op;
    assign m_wide         = rec_reg.wide;
    assign m_direction    = rec_reg.direction;
    assign m_sign_ext     = rec_reg.sign_ext;
    assign m_mode         = rec_reg.mode;
    assign m_reg_sel      = rec_reg.reg_sel;
    assign m_rm_sel       = rec_reg.rm_sel;
    assign m_displacement = rec_reg.displacement;
    assign m_immediate    = rec_reg.immediate;
    assign m_instr_length = rec_reg.instr_length;

    // A halted decoder holds no partial instruction
    a_halt_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.halted |-> state_reg.taken == 3'd0)
        else $error("halted with partial instruction");

    // At most five bytes are ever pending
    a_taken_max: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.taken < 3'd6)
        else $error("byte count out of range");

    // Bytes dropped while halted give no record
    a_halt_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && state_reg.halted |-> !emit)
        else $error("record while halted");

    // A complete instruction ends on the byte after the pending ones
    a_ok_len: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && emit && rec_next.status == x86d_pkg::ST_OK |->
            state_reg.taken != 3'd0 && rec_next.instr_length == state_reg.taken + 3'd1)
        else $error("completed length mismatch");

endmodule

`default_nettype wire

@@ src/x86d_step.sv @@
// Combinational decode step: one stream byte plus the collection state
// give the next state and at most one record. Depends on x86d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module x86d_step (
    input  wire logic [7:0]           code_byte,
    input  wire logic                 stream_end,
    input  wire x86d_pkg::dec_state_t cur,
    output x86d_pkg::dec_state_t      nxt,
    output logic                      emit,
    output x86d_pkg::dec_record_t     rec
);

    x86d_pkg::cls_t cls_in;
    x86d_pkg::cls_t cls_lat;
    x86d_pkg::cls_t cls_w;
    x86d_pkg::alu_t grp_alu;
    logic           m_lat;
    logic           m_w;
    logic [1:0]     d_lat;
    logic [1:0]     d_w;
    logic [1:0]     i_w;
    logic [2:0]     k_pos;
    logic [2:0]     k_imm;
    logic [2:0]     total;
    logic [7:0]     w_opc;
    logic [7:0]     w_modrm;
    logic [15:0]    w_disp;
    logic [15:0]    w_imm;
    logic [2:0]     w_taken;
    logic           grp_bad;
    logic           modrm_ok;
    logic           done;

    assign cls_in  = x86d_pkg::classify(code_byte);
    assign cls_lat = x86d_pkg::classify(cur.opcode);
    assign m_lat   = x86d_pkg::has_modrm(cls_lat);
    assign d_lat   = x86d_pkg::disp_len(cls_lat, cur.modrm);
    assign k_pos   = cur.taken - 3'd1 - {2'd0, m_lat};
    assign k_imm   = k_pos - {1'b0, d_lat};
    assign grp_alu = x86d_pkg::alu_code(code_byte[5:3]);

    // Take the byte into the proper latch
    always_comb begin
        w_opc   = cur.opcode;
        w_modrm = cur.modrm;
        w_disp  = cur.disp;
        w_imm   = cur.imm;
        w_taken = cur.taken + 3'd1;
        grp_bad = 1'b0;
        if (cur.taken == 3'd0) begin
            w_opc   = code_byte;
            w_modrm = 8'd0;
            w_disp  = 16'd0;
            w_imm   = 16'd0;
        end else if (m_lat && cur.taken == 3'd1) begin
            w_modrm = code_byte;
            grp_bad = (cls_lat == x86d_pkg::CLS_ALU_IMM) && (grp_alu == x86d_pkg::ALU_NONE);
        end else if (k_pos < {1'b0, d_lat}) begin
            if (k_pos == 3'd0) w_disp = {8'd0, code_byte};
            else               w_disp = {code_byte, cur.disp[7:0]};
        end else begin
            if (k_imm == 3'd0) w_imm = {8'd0, code_byte};
            else               w_imm = {code_byte, cur.imm[7:0]};
        end
    end

    assign cls_w    = (cur.taken == 3'd0) ? cls_in : cls_lat;
    assign m_w      = x86d_pkg::has_modrm(cls_w);
    assign d_w      = x86d_pkg::disp_len(cls_w, w_modrm);
    assign i_w      = x86d_pkg::imm_len(cls_w, w_opc);
    assign total    = 3'd1 + {2'd0, m_w} + {1'b0, d_w} + {1'b0, i_w};
    assign modrm_ok = m_w && (w_taken >= 3'd2);
    assign done     = !(m_w && w_taken < 3'd2) && (w_taken >= total);

    // Pick the outcome and build the record
    always_comb begin
        x86d_pkg::alu_t a;
        nxt  = cur;
        emit = 1'b0;
        rec  = '0;
        a    = x86d_pkg::alu_code(w_modrm[5:3]);
        if (cur.halted) begin
            // drop bytes until the stream ends
            if (stream_end) nxt = '0;
        end else if (cur.taken == 3'd0 && cls_in == x86d_pkg::CLS_BAD) begin
            emit              = 1'b1;
            rec.status        = x86d_pkg::ST_BAD_OP;
            rec.instr_length  = 3'd1;
            nxt               = '0;
            nxt.halted        = !stream_end;
        end else begin
            // opcode- and ModRM-derived fields
            rec.instr_class = cls_w;
            unique case (cls_w)
                x86d_pkg::CLS_MOV_RM: begin
                    rec.wide      = w_opc[0];
                    rec.direction = w_opc[1];
                end
                x86d_pkg::CLS_MOV_IMM: begin
                    rec.wide    = w_opc[3];
                    rec.reg_sel = w_opc[2:0];
                end
                x86d_pkg::CLS_ALU_RM: begin
                    rec.sub_op    = {2'd0, x86d_pkg::alu_code(w_opc[5:3])};
                    rec.wide      = w_opc[0];
                    rec.direction = w_opc[1];
                end
                x86d_pkg::CLS_ALU_IMM: begin
                    if (modrm_ok && a != x86d_pkg::ALU_NONE) rec.sub_op = {2'd0, a};
                    rec.wide     = w_opc[0];
                    rec.sign_ext = w_opc[1];
                end
                x86d_pkg::CLS_ALU_ACC: begin
                    rec.sub_op = {2'd0, x86d_pkg::alu_code(w_opc[5:3])};
                    rec.wide   = w_opc[0];
                end
                x86d_pkg::CLS_JCC:  rec.sub_op = w_opc[3:0];
                x86d_pkg::CLS_LOOP: rec.sub_op = {2'd0, w_opc[1:0]};
                default: ;
            endcase
            if (modrm_ok) begin
                rec.mode    = w_modrm[7:6];
                rec.reg_sel = w_modrm[5:3];
                rec.rm_sel  = w_modrm[2:0];
            end

            priority if (grp_bad) begin
                emit             = 1'b1;
                rec.status       = x86d_pkg::ST_BAD_GRP;
                rec.instr_length = 3'd2;
                nxt              = '0;
            end else if (done) begin
                emit             = 1'b1;
                rec.status       = x86d_pkg::ST_OK;
                rec.displacement = (d_w == 2'd1) ? x86d_pkg::sext8(w_disp) : w_disp;
                rec.immediate    = (i_w == 2'd1 && cls_w != x86d_pkg::CLS_MOV_IMM) ?
                                   x86d_pkg::sext8(w_imm) : w_imm;
                rec.instr_length = total;
                nxt              = '0;
            end else if (stream_end) begin
                emit             = 1'b1;
                rec.status       = x86d_pkg::ST_TRUNC;
                rec.instr_length = w_taken;
                nxt              = '0;
            end else begin
                nxt.opcode = w_opc;
                nxt.modrm  = w_modrm;
                nxt.disp   = w_disp;
                nxt.imm    = w_imm;
                nxt.taken  = w_taken;
                nxt.halted = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for x86_16bit_instruction_byte_decoder: directed and random byte
// streams, an in-bench decode predictor and a record scoreboard. Depends on x86d_pkg.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_BYTES = 620;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_code_byte = 8'h00;
    logic        s_stream_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [2:0]  m_instr_class;
    logic [3:0]  m_sub_op;
    logic        m_wide;
    logic        m_direction;
    logic        m_sign_ext;
    logic [1:0]  m_mode;
    logic [2:0]  m_reg_sel;
    logic [2:0]  m_rm_sel;
    logic [15:0] m_displacement;
    logic [15:0] m_immediate;
    logic [2:0]  m_instr_length;

    x86_16bit_instruction_byte_decoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_code_byte(s_code_byte), .s_stream_end(s_stream_end),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_instr_class(m_instr_class), .m_sub_op(m_sub_op),
        .m_wide(m_wide), .m_direction(m_direction), .m_sign_ext(m_sign_ext),
        .m_mode(m_mode), .m_reg_sel(m_reg_sel), .m_rm_sel(m_rm_sel),
        .m_displacement(m_displacement), .m_immediate(m_immediate),
        .m_instr_length(m_instr_length)
    );

    // Decoder model state
    logic [7:0]  pd_op;
    logic [7:0]  pd_modrm;
    logic [15:0] pd_disp;
    logic [15:0] pd_imm;
    int          pd_taken;
    bit          pd_halt;

    x86d_pkg::dec_record_t expected_records[$];
    int          fail_count = 0;
    int          report_count = 0;
    int          records_checked = 0;
    int          status_seen[4];
    int          bytes_sent = 0;
    int          bytes_decoded = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Decode predictor
    // ---------------------------------------------------------------
    function automatic x86d_pkg::cls_t class_of(input logic [7:0] op);
        casez (op)
            8'h04, 8'h05, 8'h2C, 8'h2D, 8'h3C, 8'h3D: return x86d_pkg::CLS_ALU_ACC;
            8'b100010??:                              return x86d_pkg::CLS_MOV_RM;
            8'b1011????:                              return x86d_pkg::CLS_MOV_IMM;
            8'b100000??:                              return x86d_pkg::CLS_ALU_IMM;
            8'b000000??, 8'b001010??, 8'b001110??:    return x86d_pkg::CLS_ALU_RM;
            8'b0111????:                              return x86d_pkg::CLS_JCC;
            8'b111000??:                              return x86d_pkg::CLS_LOOP;
            default:                                  return x86d_pkg::CLS_BAD;
        endcase
    endfunction

    function automatic x86d_pkg::alu_t alu_of(input logic [2:0] sel);
        case (sel)
            x86d_pkg::SEL_ADD: return x86d_pkg::ALU_ADD;
            x86d_pkg::SEL_SUB: return x86d_pkg::ALU_SUB;
            x86d_pkg::SEL_CMP: return x86d_pkg::ALU_CMP;
            default:           return x86d_pkg::ALU_NONE;
        endcase
    endfunction

    function automatic int uses_modrm(input x86d_pkg::cls_t c);
        return (c == x86d_pkg::CLS_MOV_RM || c == x86d_pkg::CLS_ALU_RM ||
                c == x86d_pkg::CLS_ALU_IMM) ? 1 : 0;
    endfunction

    function automatic int disp_bytes(input x86d_pkg::cls_t c, input logic [7:0] modrm);
        if (c == x86d_pkg::CLS_JCC || c == x86d_pkg::CLS_LOOP) return 1;
        if (uses_modrm(c) == 0) return 0;
        case (modrm[7:6])
            2'd1:    return 1;
            2'd2:    return 2;
            2'd0:    return (modrm[2:0] == x86d_pkg::RM_DIRECT) ? 2 : 0;
            default: return 0;
        endcase
    endfunction

    function automatic int imm_bytes(input x86d_pkg::cls_t c, input logic [7:0] op);
        case (c)
            x86d_pkg::CLS_MOV_IMM: return op[3] ? 2 : 1;
            x86d_pkg::CLS_ALU_ACC: return op[0] ? 2 : 1;
            x86d_pkg::CLS_ALU_IMM: return (op[0] && !op[1]) ? 2 : 1;
            default:               return 0;
        endcase
    endfunction

    function automatic logic [15:0] widen_signed(input logic [15:0] v);
        return {{8{v[7]}}, v[7:0]};
    endfunction

    // Fill the opcode and ModRM derived fields of a record
    function automatic x86d_pkg::dec_record_t base_record(input x86d_pkg::cls_t c,
                                                          input logic [7:0] op,
                                                          input logic [7:0] modrm,
                                                          input bit modrm_ok);
        x86d_pkg::dec_record_t r;
        x86d_pkg::alu_t        a;
        r = '0;
        r.instr_class = c;
        case (c)
            x86d_pkg::CLS_MOV_RM: begin
                r.wide = op[0];
                r.direction = op[1];
            end
            x86d_pkg::CLS_ALU_RM: begin
                r.sub_op = {2'b00, alu_of(op[5:3])};
                r.wide = op[0];
                r.direction = op[1];
            end
            x86d_pkg::CLS_ALU_ACC: begin
                r.sub_op = {2'b00, alu_of(op[5:3])};
                r.wide = op[0];
            end
            x86d_pkg::CLS_ALU_IMM: begin
                r.wide = op[0];
                r.sign_ext = op[1];
                if (modrm_ok) begin
                    a = alu_of(modrm[5:3]);
                    r.sub_op = (a == x86d_pkg::ALU_NONE) ? 4'd0 : {2'b00, a};
                end
            end
            x86d_pkg::CLS_MOV_IMM: begin
                r.wide = op[3];
                r.reg_sel = op[2:0];
            end
            x86d_pkg::CLS_JCC:  r.sub_op = op[3:0];
            x86d_pkg::CLS_LOOP: r.sub_op = {2'b00, op[1:0]};
            default:            r.sub_op = 4'd0;
        endcase
        if (uses_modrm(c) == 1 && modrm_ok) begin
            r.mode = modrm[7:6];
            r.reg_sel = modrm[5:3];
            r.rm_sel = modrm[2:0];
        end
        return r;
    endfunction

    task automatic clear_decoder;
        pd_op = 8'h00;
        pd_modrm = 8'h00;
        pd_disp = 16'h0000;
        pd_imm = 16'h0000;
        pd_taken = 0;
    endtask

    // Advance the model by one accepted byte; queue the record it causes
    task automatic decode_byte(input logic [7:0] b, input logic e, output bit ignored);
        x86d_pkg::cls_t        c;
        x86d_pkg::dec_record_t r;
        int                    m, d, n, k, total;
        bit                    done;
        ignored = 1'b0;
        done = 1'b0;
        c = x86d_pkg::CLS_BAD;
        if (pd_halt) begin
            // drop bytes until the stream ends
            ignored = 1'b1;
            if (e) begin
                pd_halt = 1'b0;
                clear_decoder();
            end
            done = 1'b1;
        end else if (pd_taken == 0) begin
            c = class_of(b);
            if (c == x86d_pkg::CLS_BAD) begin
                r = '0;
                r.status = x86d_pkg::ST_BAD_OP;
                r.instr_length = 3'd1;
                expected_records.push_back(r);
                clear_decoder();
                if (!e) pd_halt = 1'b1;
                done = 1'b1;
            end else begin
                clear_decoder();
                pd_op = b;
                pd_taken = 1;
            end
        end else begin
            c = class_of(pd_op);
            m = uses_modrm(c);
            if (m == 1 && pd_taken == 1) begin
                pd_modrm = b;
                pd_taken = 2;
                if (c == x86d_pkg::CLS_ALU_IMM && alu_of(b[5:3]) == x86d_pkg::ALU_NONE) begin
                    r = base_record(c, pd_op, b, 1'b1);
                    r.status = x86d_pkg::ST_BAD_GRP;
                    r.instr_length = 3'd2;
                    expected_records.push_back(r);
                    clear_decoder();
                    done = 1'b1;
                end
            end else begin
                d = disp_bytes(c, pd_modrm);
                k = pd_taken - 1 - m;
                if (k < d) begin
                    if (k == 0) pd_disp = {8'h00, b};
                    else pd_disp[15:8] = b;
                end else begin
                    k = k - d;
                    if (k == 0) pd_imm = {8'h00, b};
                    else pd_imm[15:8] = b;
                end
                pd_taken = pd_taken + 1;
            end
        end

        if (!done) begin
            m = uses_modrm(c);
            // complete instruction
            if (!(m == 1 && pd_taken < 2)) begin
                d = disp_bytes(c, pd_modrm);
                n = imm_bytes(c, pd_op);
                total = 1 + m + d + n;
                if (pd_taken >= total) begin
                    r = base_record(c, pd_op, pd_modrm, 1'b1);
                    r.status = x86d_pkg::ST_OK;
                    r.displacement = (d == 1) ? widen_signed(pd_disp) : pd_disp;
                    r.immediate = (n == 1 && c != x86d_pkg::CLS_MOV_IMM) ?
                                  widen_signed(pd_imm) : pd_imm;
                    r.instr_length = total[2:0];
                    expected_records.push_back(r);
                    clear_decoder();
                    done = 1'b1;
                end
            end
            // stream ended mid-instruction
            if (!done && e) begin
                r = base_record(c, pd_op, pd_modrm, m == 1 && pd_taken >= 2);
                r.status = x86d_pkg::ST_TRUNC;
                r.instr_length = pd_taken[2:0];
                expected_records.push_back(r);
                clear_decoder();
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 6);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [2:0] alu_selector();
        case ($urandom_range(0, 2))
            0:       return x86d_pkg::SEL_ADD;
            1:       return x86d_pkg::SEL_SUB;
            default: return x86d_pkg::SEL_CMP;
        endcase
    endfunction

    // Send one request byte and update the model when it is taken
    task automatic send_byte(input logic [7:0] b, input logic e);
        int gap;
        bit ign;
        gap = 0;
        if (!tx_steady && $urandom_range(0, 99) < 35) gap = idle_length();
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_code_byte <= b;
        s_stream_end <= e;
        do @(posedge aclk); while (!s_ready);
        decode_byte(b, e, ign);
        bytes_sent++;
        if (!ign) bytes_decoded++;
    endtask

    // Hold off the sender until every queued record has arrived
    task automatic hold_until_drained;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge aclk);
    endtask

    // One well-formed instruction with random content, sometimes cut short
    task automatic send_instruction;
        logic [7:0]     code [0:5];
        logic [7:0]     op;
        logic [7:0]     mrm;
        logic [2:0]     sel;
        x86d_pkg::cls_t c;
        int             len, n, i;
        bit             flag_last;
        sel = alu_selector();
        case ($urandom_range(0, 6))
            0:       op = 8'h88 | 8'($urandom_range(0, 3));
            1:       op = 8'hB0 | 8'($urandom_range(0, 15));
            2:       op = {2'b00, sel, 3'b000} | 8'($urandom_range(0, 3));
            3:       op = 8'h80 | 8'($urandom_range(0, 3));
            4:       op = {2'b00, sel, 3'b100} | 8'($urandom_range(0, 1));
            5:       op = 8'h70 | 8'($urandom_range(0, 15));
            default: op = 8'hE0 | 8'($urandom_range(0, 3));
        endcase
        mrm = 8'($urandom_range(0, 255));
        c = class_of(op);
        if (c == x86d_pkg::CLS_ALU_IMM && $urandom_range(0, 9) != 0) mrm[5:3] = alu_selector();
        code[0] = op;
        len = 1;
        if (uses_modrm(c) == 1) begin
            code[1] = mrm;
            len = 2;
        end
        if (!(c == x86d_pkg::CLS_ALU_IMM && alu_of(mrm[5:3]) == x86d_pkg::ALU_NONE)) begin
            n = disp_bytes(c, mrm) + imm_bytes(c, op);
            repeat (n) begin
                // lean on sign boundaries for displacement and immediate bytes
                case ($urandom_range(0, 7))
                    0:       code[len] = 8'h00;
                    1:       code[len] = 8'hFF;
                    2:       code[len] = 8'h80;
                    3:       code[len] = 8'h7F;
                    default: code[len] = 8'($urandom_range(0, 255));
                endcase
                len++;
            end
        end
        n = len;
        flag_last = ($urandom_range(0, 9) == 0);
        if (len > 1 && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, len - 1);
            flag_last = 1'b1;
        end
        for (i = 0; i < n; i++) send_byte(code[i], flag_last && i == n - 1);
    endtask

    // Unsupported opcodes with trailing junk, or plain noise ending the stream
    task automatic send_junk;
        logic [7:0] op;
        int         n, i;
        if ($urandom_range(0, 1) == 1) begin
            do op = 8'($urandom_range(0, 255)); while (class_of(op) != x86d_pkg::CLS_BAD);
            if ($urandom_range(0, 5) == 0) begin
                send_byte(op, 1'b1);
            end else begin
                send_byte(op, 1'b0);
                repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        end else begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), i == n - 1);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_mov_forms;
        send_byte(8'h8B, 1'b0);     // mov word reg <- rm, register form
        send_byte(8'hD8, 1'b0);
        send_byte(8'hB7, 1'b0);     // mov bh, imm8 stays zero-extended
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_alu_forms;
        // add word [direct], imm16: longest instruction
        send_byte(8'h81, 1'b0);
        send_byte(8'h06, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        // sub [bx+si+disp8], sign-extended imm8
        send_byte(8'h83, 1'b0);
        send_byte(8'h68, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // cmp al, imm8
        send_byte(8'h3C, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    task automatic test_branch_forms;
        send_byte(8'h7F, 1'b0);     // jg, negative offset
        send_byte(8'h80, 1'b0);
        send_byte(8'hE3, 1'b0);     // jcxz, positive offset
        send_byte(8'h7F, 1'b0);
    endtask

    task automatic test_unsupported;
        send_byte(8'h80, 1'b0);     // group op outside add/sub/cmp
        send_byte(8'hC8, 1'b0);
        send_byte(8'h0F, 1'b0);     // unsupported opcode, rest of stream ignored
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_truncation;
        send_byte(8'h29, 1'b0);     // stream ends after ModRM of a disp16 form
        send_byte(8'h87, 1'b1);
        send_byte(8'h05, 1'b1);     // stream ends on the opcode itself
    endtask

    task automatic test_random_stream;
        int start, phase, next_drain, pick;
        start = bytes_sent;
        next_drain = start + 150;
        while (bytes_sent - start < RANDOM_BYTES) begin
            // alternate stretches of idling on both sides, steady on both, and idling on the send side only
            phase = ((bytes_sent - start) / 80) % 4;
            tx_steady = (phase == 1);
            rx_steady = (phase == 1 || phase == 3);
            if (bytes_sent >= next_drain) begin
                hold_until_drained();
                next_drain = bytes_sent + 150;
            end
            pick = $urandom_range(0, 99);
            if (pick < 75) send_instruction();
            else send_junk();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Result side: random stalls and record check
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!rx_steady && $urandom_range(0, 99) < 15) begin
            stall_left = idle_length() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic string record_diff(input x86d_pkg::dec_record_t x,
                                          input x86d_pkg::dec_record_t g);
        string s;
        s = "";
        if (g.status !== x.status)
            s = {s, $sformatf(" status %0d/%0d", x.status, g.status)};
        if (g.instr_class !== x.instr_class)
            s = {s, $sformatf(" class %0d/%0d", x.instr_class, g.instr_class)};
        if (g.sub_op !== x.sub_op)
            s = {s, $sformatf(" sub_op %0d/%0d", x.sub_op, g.sub_op)};
        if (g.wide !== x.wide)
            s = {s, $sformatf(" wide %0b/%0b", x.wide, g.wide)};
        if (g.direction !== x.direction)
            s = {s, $sformatf(" direction %0b/%0b", x.direction, g.direction)};
        if (g.sign_ext !== x.sign_ext)
            s = {s, $sformatf(" sign_ext %0b/%0b", x.sign_ext, g.sign_ext)};
        if (g.mode !== x.mode)
            s = {s, $sformatf(" mode %0d/%0d", x.mode, g.mode)};
        if (g.reg_sel !== x.reg_sel)
            s = {s, $sformatf(" reg_sel %0d/%0d", x.reg_sel, g.reg_sel)};
        if (g.rm_sel !== x.rm_sel)
            s = {s, $sformatf(" rm_sel %0d/%0d", x.rm_sel, g.rm_sel)};
        if (g.displacement !== x.displacement)
            s = {s, $sformatf(" disp %h/%h", x.displacement, g.displacement)};
        if (g.immediate !== x.immediate)
            s = {s, $sformatf(" imm %h/%h", x.immediate, g.immediate)};
        if (g.instr_length !== x.instr_length)
            s = {s, $sformatf(" length %0d/%0d", x.instr_length, g.instr_length)};
        return s;
    endfunction

    // Compare each accepted record with the oldest queued one
    always @(posedge aclk) begin
        x86d_pkg::dec_record_t got;
        x86d_pkg::dec_record_t want;
        string                 diff;
        if (aresetn && m_valid && m_ready) begin
            got.status = x86d_pkg::status_t'(m_status);
            got.instr_class = m_instr_class;
            got.sub_op = m_sub_op;
            got.wide = m_wide;
            got.direction = m_direction;
            got.sign_ext = m_sign_ext;
            got.mode = m_mode;
            got.reg_sel = m_reg_sel;
            got.rm_sel = m_rm_sel;
            got.displacement = m_displacement;
            got.immediate = m_immediate;
            got.instr_length = m_instr_length;
            if (expected_records.size() == 0) begin
                fail_count++;
                if (report_count < 10)
                    $display("[%0t] unexpected record, status %0d class %0d length %0d",
                             $realtime, got.status, got.instr_class, got.instr_length);
                report_count++;
            end else begin
                want = expected_records.pop_front();
                status_seen[want.status]++;
                diff = record_diff(want, got);
                if (diff != "") begin
                    fail_count++;
                    if (report_count < 10)
                        $display("[%0t] record %0d mismatch (expected/actual):%s",
                                 $realtime, records_checked, diff);
                    report_count++;
                end
            end
            records_checked++;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d records outstanding",
                     cycle_count, expected_records.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        pd_halt = 1'b0;
        clear_decoder();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_mov_forms();
        test_alu_forms();
        test_branch_forms();
        test_unsupported();
        test_truncation();
        test_random_stream();

        hold_until_drained();
        repeat (8) @(posedge aclk);
        fail_count += expected_records.size();

        $display("Covered %0d stream bytes (%0d decoded) and %0d records:", bytes_sent,
                 bytes_decoded, records_checked);
        $display("  %0d complete, %0d unsupported opcode, %0d truncated, %0d bad group op",
                 status_seen[x86d_pkg::ST_OK], status_seen[x86d_pkg::ST_BAD_OP],
                 status_seen[x86d_pkg::ST_TRUNC], status_seen[x86d_pkg::ST_BAD_GRP]);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches in total", fail_count);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
